[sv/assert_macros.svh]
// assertion macros for the rtl files, included by ccl_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define CCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define CCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/ccl_pkg.sv]
// ----------------------------------------------------------------------------
// ccl_pkg
// types, constants and helpers shared by the crossbar locator modules
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    localparam int X_W      = 9;
    localparam int Y_W      = 8;
    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int KEPT_W   = 10;
    localparam int KEPT_MAX = 1023;
    localparam int SUMX_W   = 20;
    localparam int SUMY_W   = 19;
    localparam int DIV_W    = SUMX_W;
    localparam int DVS_W    = KEPT_W + 1;
    localparam int ITER_W   = $clog2(DIV_W);
    localparam int SLOPE_W  = 16;
    localparam int MIN_W    = 9;
    localparam int CFG_W    = 16;
    localparam int PROD_W   = SLOPE_W + X_W;
    localparam int LX2_W    = 2 * X_W;
    localparam int LY2_W    = 2 * Y_W;
    localparam int LEN2_W   = LX2_W + 1;
    localparam int MIN2_W   = 2 * MIN_W;
    localparam int DIST_W   = 8;

    localparam logic [MIN_W-1:0]   MIN_BAR_RESET = MIN_W'(60);
    localparam logic [SLOPE_W-1:0] SLOPE_RESET   = SLOPE_W'(47615);

    // configuration register indexes
    localparam logic CFG_MIN_BAR_LEN = 1'b0;
    localparam logic CFG_SLOPE       = 1'b1;

    typedef struct packed {
        logic accept;       // vertex transaction taken
        logic close;        // current edge is the closing edge
        logic mul;          // product stage of an edge
        logic dec;          // decision and update stage of an edge
        logic div_start_x;
        logic div_start_y;
        logic latch_qx;
        logic load_result;
        logic clear;        // contour state back to reset values
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic last;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [X_W-1:0] absdiff_x(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [Y_W-1:0] absdiff_y(input logic [Y_W-1:0] a,
                                                 input logic [Y_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[sv/ccl_div.sv]
// ----------------------------------------------------------------------------
// ccl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ccl_div import ccl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic [DIV_W-1:0]  o_quotient,
    output logic              o_busy,
    output logic              o_done
);

    logic [DIV_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    rem_sh;
    logic              ge;
    logic [DVS_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == ITER_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

[sv/ccl_dp.sv]
// ----------------------------------------------------------------------------
// ccl_dp
// datapath: vertex and run registers, edge products, sums, divider, result
// ----------------------------------------------------------------------------
module ccl_dp import ccl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [X_W-1:0]     i_vertex_x,
    input  logic [Y_W-1:0]     i_vertex_y,
    input  logic               i_final_vertex,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_bar_found,
    output logic [DIST_W-1:0]  o_bar_distance,
    output logic [X_W-1:0]     o_bar_center_x,
    output logic [KEPT_W-1:0]  o_bar_count
);

    // configuration
    logic [MIN_W-1:0]   r_min_bar;
    logic [SLOPE_W-1:0] r_slope;
    logic [MIN2_W-1:0]  r_min_sq;

    // contour state
    logic [X_W-1:0]    r_first_x, r_prev_x, r_cur_x;
    logic [Y_W-1:0]    r_first_y, r_prev_y, r_cur_y;
    logic              r_last;
    logic [CNT_W-1:0]  r_count;
    logic [X_W-1:0]    r_left_x, r_right_x;
    logic [Y_W-1:0]    r_left_y, r_right_y;
    logic              r_run_active;
    logic [SUMX_W-1:0] r_sum_x;
    logic [SUMY_W-1:0] r_sum_y;
    logic [KEPT_W-1:0] r_kept;

    // product stage
    logic [PROD_W-1:0] r_slope_prod;
    logic [Y_W-1:0]    r_ady;
    logic [LX2_W-1:0]  r_lx2;
    logic [LY2_W-1:0]  r_ly2;

    // division
    logic [DIV_W-1:0]  r_qx;
    logic [DIV_W-1:0]  div_q;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_busy;
    logic              div_done;

    // output register
    logic              r_out_valid;
    logic              r_found;
    logic [DIST_W-1:0] r_dist;
    logic [X_W-1:0]    r_cx;
    logic [KEPT_W-1:0] r_cnt;

    logic [X_W-1:0]    x0, x1, adx, lx;
    logic [Y_W-1:0]    y0, y1, ady, ly;
    logic              horiz;
    logic              keep;
    logic [LEN2_W-1:0] len2;
    logic [X_W-1:0]    n_left_x, n_right_x, left_a_x, right_a_x;
    logic [Y_W-1:0]    n_left_y, n_right_y, left_a_y, right_a_y;
    logic              enough;
    logic              n_found;
    logic [DIST_W-1:0] n_dist;

    // edge endpoints: open edge runs prev to cur, closing edge runs cur to first
    always_comb begin
        x0  = i_cmd.close ? r_cur_x   : r_prev_x;
        y0  = i_cmd.close ? r_cur_y   : r_prev_y;
        x1  = i_cmd.close ? r_first_x : r_cur_x;
        y1  = i_cmd.close ? r_first_y : r_cur_y;
        adx = absdiff_x(x1, x0);
        ady = absdiff_y(y1, y0);
        lx  = absdiff_x(r_right_x, r_left_x);
        ly  = absdiff_y(r_right_y, r_left_y);
    end

    always_comb begin
        horiz = ({1'b0, r_ady, 16'd0} <= r_slope_prod);
        len2  = LEN2_W'(r_lx2) + LEN2_W'(r_ly2);
        keep  = (len2 > LEN2_W'(r_min_sq)) && (r_kept < KEPT_W'(KEPT_MAX));

        // two points in order, ties go to the later point
        if (x0 <= r_left_x) begin
            left_a_x = x0;
            left_a_y = y0;
        end else begin
            left_a_x = r_left_x;
            left_a_y = r_left_y;
        end
        if (x0 >= r_right_x) begin
            right_a_x = x0;
            right_a_y = y0;
        end else begin
            right_a_x = r_right_x;
            right_a_y = r_right_y;
        end
        if (x1 <= left_a_x) begin
            n_left_x = x1;
            n_left_y = y1;
        end else begin
            n_left_x = left_a_x;
            n_left_y = left_a_y;
        end
        if (x1 >= right_a_x) begin
            n_right_x = x1;
            n_right_y = y1;
        end else begin
            n_right_x = right_a_x;
            n_right_y = right_a_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bar <= MIN_BAR_RESET;
            r_slope   <= SLOPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_BAR_LEN: r_min_bar <= i_cfg_data[MIN_W-1:0];
                CFG_SLOPE:       r_slope   <= i_cfg_data[SLOPE_W-1:0];
                default:         r_slope   <= r_slope;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= MIN2_W'(r_min_bar) * MIN2_W'(r_min_bar);
        if (i_cmd.mul) begin
            r_slope_prod <= PROD_W'(r_slope) * PROD_W'(adx);
            r_ady        <= ady;
            r_lx2        <= LX2_W'(lx) * LX2_W'(lx);
            r_ly2        <= LY2_W'(ly) * LY2_W'(ly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_x <= i_vertex_x;
            r_cur_y <= i_vertex_y;
            r_last  <= i_final_vertex;
        end
        if (i_cmd.accept && r_count == '0) begin
            r_first_x <= i_vertex_x;
            r_first_y <= i_vertex_y;
            r_prev_x  <= i_vertex_x;
            r_prev_y  <= i_vertex_y;
        end else if (i_cmd.dec && !i_cmd.close) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count      <= '0;
            r_left_x     <= X_W'(FRAME_WIDTH);
            r_left_y     <= '0;
            r_right_x    <= '0;
            r_right_y    <= '0;
            r_run_active <= 1'b0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_kept       <= '0;
        end else begin
            if (i_cmd.accept && r_count != CNT_W'(MAX_VERTICES)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.dec) begin
                if (horiz) begin
                    r_left_x     <= n_left_x;
                    r_left_y     <= n_left_y;
                    r_right_x    <= n_right_x;
                    r_right_y    <= n_right_y;
                    r_run_active <= 1'b1;
                end else if (r_run_active) begin
                    if (keep) begin
                        r_sum_x <= r_sum_x + SUMX_W'(r_left_x) + SUMX_W'(r_right_x);
                        r_sum_y <= r_sum_y + SUMY_W'(r_left_y) + SUMY_W'(r_right_y);
                        r_kept  <= r_kept + 1'b1;
                    end
                    r_left_x     <= X_W'(FRAME_WIDTH);
                    r_left_y     <= '0;
                    r_right_x    <= '0;
                    r_right_y    <= '0;
                    r_run_active <= 1'b0;
                end
            end
        end
    end

    assign div_dividend = i_cmd.div_start_y ? DIV_W'(r_sum_y) : r_sum_x;

    ccl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start_x | i_cmd.div_start_y),
        .i_dividend (div_dividend),
        .i_divisor  ({r_kept, 1'b0}),
        .o_quotient (div_q),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_qx) begin
            r_qx <= div_q;
        end
    end

    always_comb begin
        enough  = (r_count >= CNT_W'(3));
        n_found = enough && (r_kept != '0);
        n_dist  = (div_q > DIV_W'(FRAME_HEIGHT)) ? '0
                : DIST_W'(DIV_W'(FRAME_HEIGHT) - div_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_found <= n_found;
            r_dist  <= n_found ? n_dist : '0;
            r_cx    <= n_found ? r_qx[X_W-1:0] : '0;
            r_cnt   <= enough ? r_kept : '0;
        end
    end

    always_comb begin
        o_sts.count_zero = (r_count == '0);
        o_sts.last       = r_last;
        o_sts.div_busy   = div_busy;
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_bar_found    = r_found;
    assign o_bar_distance = r_dist;
    assign o_bar_center_x = r_cx;
    assign o_bar_count    = r_cnt;

endmodule

[sv/ccl_ctrl.sv]
// ----------------------------------------------------------------------------
// ccl_ctrl
// controller: sequences vertex intake, edge stages, division and result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccl_ctrl import ccl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_final_vertex,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_DEC  = 7'b0000100,
        S_DIVS = 7'b0001000,
        S_DIVX = 7'b0010000,
        S_DIVY = 7'b0100000,
        S_RES  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_close, n_close;
    logic   in_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_close <= n_close;
        end
    end

    always_comb begin
        n_state = r_state;
        n_close = r_close;
        o_cmd   = '0;
        o_cmd.close = r_close;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.count_zero) begin
                        n_close = 1'b0;
                        n_state = S_MUL;
                    end else if (i_final_vertex) begin
                        n_close = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                if (r_close) begin
                    n_state = S_DIVS;
                end else if (i_sts.last) begin
                    n_close = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // sums and kept count settle after the closing edge update
            S_DIVS: begin
                o_cmd.div_start_x = 1'b1;
                n_state = S_DIVX;
            end
            S_DIVX: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_qx    = 1'b1;
                    o_cmd.div_start_y = 1'b1;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (i_sts.div_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.load_result = 1'b1;
                    o_cmd.clear       = 1'b1;
                    n_close = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_div     = (r_state == S_DIVX) || (r_state == S_DIVY);

    `CCL_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.load_result, i_sts.out_free)
    `CCL_ASSERT_IMP(a_div_live, i_clk, i_rst_n, in_div, i_sts.div_busy || i_sts.div_done)
    `CCL_ASSERT_NXT(a_start_div, i_clk, i_rst_n, o_cmd.div_start_x || o_cmd.div_start_y, i_sts.div_busy && !i_sts.div_done)
    `CCL_ASSERT_NXT(a_clear_zero, i_clk, i_rst_n, o_cmd.clear, i_sts.count_zero)

endmodule

[sv/contour_crossbar_locator.sv]
// ----------------------------------------------------------------------------
// contour_crossbar_locator
// finds long near-horizontal runs along a closed contour and reports the
// average endpoint position of the kept runs once per contour
// ----------------------------------------------------------------------------
// sequence: a vertex that is not final passes intake, product and update;
//   the first vertex of a contour passes intake only unless it is also final
// final vertex: own edge, closing edge, two 20-step divisions, then the result
//   loads when the output is free and intake resumes; a lone vertex has no own edge
// intake: a new vertex waits until the last one is through product and update
// reset: synchronous active low, contour state cleared, registers to 60, 47615
module contour_crossbar_locator import ccl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // vertex channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [X_W-1:0]     i_vertex_x,
    input  logic [Y_W-1:0]     i_vertex_y,
    input  logic               i_final_vertex,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_bar_found,
    output logic [DIST_W-1:0]  o_bar_distance,
    output logic [X_W-1:0]     o_bar_center_x,
    output logic [KEPT_W-1:0]  o_bar_count,
    // configuration write port, index 0 min_bar_length, 1 horizontal_slope_q16
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // command and status between controller and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: one-hot sequencer, accepts a vertex transaction only when idle;
    // a result waiting in the output register does not block new vertices
    ccl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_final_vertex (i_final_vertex),
        .o_in_stall     (o_in_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    // datapath: edge slope test |dy|*2^16 <= slope*|dx|, run tracking,
    // squared-length check, coordinate sums, divider and output register
    ccl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_final_vertex (i_final_vertex),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_bar_found    (o_bar_found),
        .o_bar_distance (o_bar_distance),
        .o_bar_center_x (o_bar_center_x),
        .o_bar_count    (o_bar_count)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contour crossbar locator testbench
// drives closed contours into the block vertex by vertex under random idle
// cycles on both channels, predicts the per-contour bar report in a
// scoreboard class and checks every report field by field
// ----------------------------------------------------------------------------
module testbench;
    import ccl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int IDLE_PCT     = 23;

    // one bar report as the result channel carries it
    typedef struct {
        logic              found;
        logic [DIST_W-1:0] distance;
        logic [X_W-1:0]    center_x;
        logic [KEPT_W-1:0] count;
    } bar_report_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks contour state and registers, queues the reports
    // ------------------------------------------------------------------------
    class crossbar_scoreboard;
        logic [MIN_W-1:0]   min_len;
        logic [SLOPE_W-1:0] slope;
        logic [X_W-1:0]     first_x, prev_x, left_x, right_x;
        logic [Y_W-1:0]     first_y, prev_y, left_y, right_y;
        logic [CNT_W-1:0]   vertex_count;
        logic               run_open;
        logic [SUMX_W-1:0]  sum_x;
        logic [SUMY_W-1:0]  sum_y;
        logic [KEPT_W-1:0]  kept;
        bar_report_t        expected_reports[$];
        int                 mismatches;
        int                 reports_checked;
        int                 reports_found;
        int                 vertices_noted;
        int                 contours_noted;

        function new();
            min_len = MIN_BAR_RESET;
            slope   = SLOPE_RESET;
            mismatches      = 0;
            reports_checked = 0;
            reports_found   = 0;
            vertices_noted  = 0;
            contours_noted  = 0;
            clear_contour();
        endfunction

        function void clear_run();
            left_x   = X_W'(FRAME_WIDTH);
            left_y   = '0;
            right_x  = '0;
            right_y  = '0;
            run_open = 1'b0;
        endfunction

        function void clear_contour();
            first_x      = '0;
            first_y      = '0;
            prev_x       = '0;
            prev_y       = '0;
            vertex_count = '0;
            sum_x        = '0;
            sum_y        = '0;
            kept         = '0;
            clear_run();
        endfunction

        function void set_register(logic index, logic [CFG_W-1:0] value);
            if (index == CFG_MIN_BAR_LEN) begin
                min_len = value[MIN_W-1:0];
            end else begin
                slope = value[SLOPE_W-1:0];
            end
        endfunction

        // later point wins on equal x
        function void take_point(logic [X_W-1:0] x, logic [Y_W-1:0] y);
            if (x <= left_x) begin
                left_x = x;
                left_y = y;
            end
            if (x >= right_x) begin
                right_x = x;
                right_y = y;
            end
            run_open = 1'b1;
        endfunction

        function void walk_edge(logic [X_W-1:0] x0, logic [Y_W-1:0] y0,
                                logic [X_W-1:0] x1, logic [Y_W-1:0] y1);
            longint unsigned adx, ady, lx, ly, m;
            adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
            if ((ady << 16) <= 64'(slope) * adx) begin
                take_point(x0, y0);
                take_point(x1, y1);
            end else if (run_open) begin
                // a steep edge closes the open run
                lx = (right_x >= left_x) ? right_x - left_x : left_x - right_x;
                ly = (right_y >= left_y) ? right_y - left_y : left_y - right_y;
                m  = min_len;
                if (lx * lx + ly * ly > m * m && kept < KEPT_W'(KEPT_MAX)) begin
                    sum_x += left_x + right_x;
                    sum_y += left_y + right_y;
                    kept++;
                end
                clear_run();
            end
        endfunction

        function void note_vertex(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic last);
            bar_report_t report;
            int unsigned divisor, avg_x, avg_y;
            int          row_gap;
            vertices_noted++;
            if (vertex_count == 0) begin
                first_x = x;
                first_y = y;
            end else begin
                walk_edge(prev_x, prev_y, x, y);
            end
            prev_x = x;
            prev_y = y;
            if (vertex_count < MAX_VERTICES) vertex_count++;
            if (!last) return;
            // closing edge back to the first vertex, open run is dropped
            walk_edge(x, y, first_x, first_y);
            report.found    = 1'b0;
            report.distance = '0;
            report.center_x = '0;
            report.count    = '0;
            if (vertex_count >= 3) begin
                report.count = kept;
                if (kept != 0) begin
                    divisor = 2 * kept;
                    avg_x   = sum_x / divisor;
                    avg_y   = sum_y / divisor;
                    row_gap = FRAME_HEIGHT - int'(avg_y);
                    if (row_gap < 0) row_gap = 0;
                    if (row_gap > 255) row_gap = 255;
                    report.found    = 1'b1;
                    report.distance = row_gap[DIST_W-1:0];
                    report.center_x = avg_x[X_W-1:0];
                end
            end
            expected_reports.insert(expected_reports.size(), report);
            contours_noted++;
            clear_contour();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(logic found, logic [DIST_W-1:0] distance,
                                   logic [X_W-1:0] center_x, logic [KEPT_W-1:0] count);
            bar_report_t want;
            if (expected_reports.size() == 0) begin
                mismatches++;
                $display("%0t ns: report expected none actual found %0d dist %0d x %0d cnt %0d",
                         $time, found, distance, center_x, count);
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            if (want.found) reports_found++;
            compare_field("bar_found",    16'(want.found),    16'(found));
            compare_field("bar_distance", 16'(want.distance), 16'(distance));
            compare_field("bar_center_x", 16'(want.center_x), 16'(center_x));
            compare_field("bar_count",    16'(want.count),    16'(count));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [X_W-1:0]    i_vertex_x;
    logic [Y_W-1:0]    i_vertex_y;
    logic              i_final_vertex;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_bar_found;
    logic [DIST_W-1:0] o_bar_distance;
    logic [X_W-1:0]    o_bar_center_x;
    logic [KEPT_W-1:0] o_bar_count;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    contour_crossbar_locator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_final_vertex (i_final_vertex),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bar_found    (o_bar_found),
        .o_bar_distance (o_bar_distance),
        .o_bar_center_x (o_bar_center_x),
        .o_bar_count    (o_bar_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    crossbar_scoreboard sb = new();

    logic steady   = 1'b0;   // no idle cycles on either side while set
    logic hold_req = 1'b0;   // asks for the long receiver hold-off
    logic hold_on  = 1'b0;
    int   cycle_count = 0;
    int   settings_used = 0;

    // ------------------------------------------------------------------------
    // result side: random stall at the falling edge, check at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= hold_on || (!steady && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_report(o_bar_found, o_bar_distance, o_bar_center_x, o_bar_count);
        end
    end

    // long hold-off counted here so the sender keeps offering vertices
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, sb.pending());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // vertex side tasks, all called and returning at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_vertex(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                               input logic last);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_vertex_x     <= x;
        i_vertex_y     <= y;
        i_final_vertex <= last;
        // transaction completes at the first rising edge without stall
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_vertex(x, y, last);
        @(negedge i_clk);
    endtask

    // wait for every report, then let the block fall idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [MIN_W-1:0] min_len,
                             input logic [SLOPE_W-1:0] slope);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MIN_BAR_LEN;
        i_cfg_data  <= CFG_W'(min_len);
        @(negedge i_clk);
        i_cfg_index <= CFG_SLOPE;
        i_cfg_data  <= CFG_W'(slope);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(CFG_MIN_BAR_LEN, CFG_W'(min_len));
        sb.set_register(CFG_SLOPE, CFG_W'(slope));
        settings_used++;
        @(negedge i_clk);
    endtask

    function automatic int jitter(int lo, int hi);
        int step;
        step = $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? step : -step;
    endfunction

    // one random contour: mostly a walk of flat and steep edges, some noise
    task automatic random_contour();
        int kind, len, k, x, y;
        kind = $urandom_range(0, 9);
        len  = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
        x    = $urandom_range(0, FRAME_WIDTH - 1);
        y    = $urandom_range(0, FRAME_HEIGHT - 1);
        for (k = 0; k < len; k++) begin
            if (kind == 1) begin
                x = $urandom_range(0, FRAME_WIDTH - 1);
                y = $urandom_range(0, FRAME_HEIGHT - 1);
            end else if (k != 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    x += jitter(0, 150);
                    y += jitter(0, 12);
                end else begin
                    x += jitter(0, 10);
                    y += jitter(30, 150);
                end
                if (x < 0) x = 0;
                if (x > FRAME_WIDTH - 1) x = FRAME_WIDTH - 1;
                if (y < 0) y = 0;
                if (y > FRAME_HEIGHT - 1) y = FRAME_HEIGHT - 1;
            end
            send_vertex(X_W'(x), Y_W'(y), k == len - 1);
        end
    endtask

    task automatic run_contours(input int budget);
        int target;
        target = sb.vertices_noted + budget;
        while (sb.vertices_noted < target) random_contour();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int                 p, g, a, b, lo, hi;
        logic [MIN_W-1:0]   m;
        logic [SLOPE_W-1:0] s;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_vertex_x     = '0;
        i_vertex_y     = '0;
        i_final_vertex = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MIN_BAR_LEN;
        i_cfg_data     = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed contours at the reset register values
        // single vertex, then two vertices at the field extremes: not found
        send_vertex(X_W'(0), Y_W'(0), 1'b1);
        send_vertex(X_W'(FRAME_WIDTH - 1), Y_W'(FRAME_HEIGHT - 1), 1'b0);
        send_vertex(X_W'(0), Y_W'(0), 1'b1);
        // rectangle, both flat sides kept, second one via the closing edge
        send_vertex(X_W'(10), Y_W'(100), 1'b0);
        send_vertex(X_W'(300), Y_W'(100), 1'b0);
        send_vertex(X_W'(300), Y_W'(200), 1'b0);
        send_vertex(X_W'(10), Y_W'(200), 1'b1);
        // run still open after the closing edge is dropped
        send_vertex(X_W'(20), Y_W'(100), 1'b0);
        send_vertex(X_W'(20), Y_W'(30), 1'b0);
        send_vertex(X_W'(200), Y_W'(30), 1'b0);
        send_vertex(X_W'(319), Y_W'(35), 1'b1);
        // average row below the frame bottom gives distance 0, full x width
        send_vertex(X_W'(0), Y_W'(250), 1'b0);
        send_vertex(X_W'(511), Y_W'(250), 1'b0);
        send_vertex(X_W'(511), Y_W'(255), 1'b0);
        send_vertex(X_W'(0), Y_W'(255), 1'b1);
        // equal x endpoints, later point wins
        send_vertex(X_W'(60), Y_W'(120), 1'b0);
        send_vertex(X_W'(200), Y_W'(122), 1'b0);
        send_vertex(X_W'(60), Y_W'(124), 1'b0);
        send_vertex(X_W'(60), Y_W'(230), 1'b1);
        // length exactly the minimum is not kept, one more is
        send_vertex(X_W'(0), Y_W'(10), 1'b0);
        send_vertex(X_W'(60), Y_W'(10), 1'b0);
        send_vertex(X_W'(60), Y_W'(200), 1'b1);
        send_vertex(X_W'(0), Y_W'(10), 1'b0);
        send_vertex(X_W'(61), Y_W'(10), 1'b0);
        send_vertex(X_W'(61), Y_W'(200), 1'b1);
        settle();

        // random contours under several register settings
        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    m = '0;
                    s = '0;
                end
                1: begin
                    m = MIN_W'(400);
                    s = '1;
                end
                default: begin
                    m = MIN_W'($urandom_range(0, 400));
                    s = SLOPE_W'($urandom_range(0, 65535));
                end
            endcase
            configure(m, s);
            hold_req = (p == 1) ? 1'b1 : hold_req;   // long hold-off during phase 1
            steady   = (p == 2);                     // no idling in phase 2
            run_contours(75);
            settle();
        end
        steady = 1'b0;

        // one long contour of stacked rectangles with many kept runs
        configure('0, SLOPE_RESET);
        for (g = 0; g < 30; g++) begin
            a  = $urandom_range(0, 150);
            b  = $urandom_range(170, FRAME_WIDTH - 1);
            lo = $urandom_range(0, 40);
            hi = $urandom_range(200, FRAME_HEIGHT - 1);
            send_vertex(X_W'(a), Y_W'(lo), 1'b0);
            send_vertex(X_W'(b), Y_W'(lo), 1'b0);
            send_vertex(X_W'(b), Y_W'(hi), 1'b0);
            send_vertex(X_W'(a), Y_W'(hi), g == 29);
        end
        settle();

        $display("covered %0d vertices in %0d contours under %0d register settings",
                 sb.vertices_noted, sb.contours_noted, settings_used + 1);
        $display("checked %0d bar reports, %0d with a bar found, %0d mismatches",
                 sb.reports_checked, sb.reports_found, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ccl_pkg.sv
sv/ccl_div.sv
sv/ccl_dp.sv
sv/ccl_ctrl.sv
sv/contour_crossbar_locator.sv
tb/sv/testbench.sv
